FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/esd_pkg.sv
package esd_pkg;

  // Sample and coefficient format
  localparam int SAMPLE_W       = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_SHIFT     = 24 - COEF_FRAC_BITS;
  // Coefficients stay below one, so frac bits plus a sign bit suffice
  localparam int COEF_W         = COEF_FRAC_BITS + 1;

  // Coefficients held with 24 fraction bits, rounded to nearest
  localparam longint K1_Q24 = 64'd3254463;
  localparam longint K2_Q24 = 64'd9936457;
  localparam longint K1_VAL = (((K1_Q24 << 1) >> COEF_SHIFT) + 1) >> 1;
  localparam longint K2_VAL = (((K2_Q24 << 1) >> COEF_SHIFT) + 1) >> 1;

  // Filter datapath widths
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + COEF_W;
  localparam int Y_W    = PROD_W + 1;

  // Configuration registers
  localparam int THRESH_W  = 42;
  localparam int CMP_W     = (Y_W > THRESH_W) ? Y_W : THRESH_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = THRESH_W;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd1;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_EVAL   = 1'b1
  } esd_op_e;

  // Evaluate command fields of the staged input word
  typedef struct packed {
    esd_op_e op;
    logic    moving;
    logic    pushing;
    logic    blocked;
  } esd_cmd_t;

  // Result word
  typedef struct packed {
    logic report;
    logic suppressed;
    logic detected;
  } esd_result_t;

endpackage

FILE: rtl/extruder_stall_detector.sv
// Channel | Handshake                  | Word
// in      | in_valid_i / in_ready_o    | opcode, sample_value, extruder flags, blocked
// out     | out_valid_o / out_ready_i  | stall_report, stall_suppressed, detected_flag
// cfg     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One word per cycle sustained while the output is not stalled; a word moves from the
// input register into the result register, which drives the output directly.
// The filter and flag update sit between the input and result registers.
// Reset clears delay line, flags, settings and both valid bits at once.
// An output stall holds the result; the input register still takes one more word.
// A register write waits while a staged word moves into the result register.
module extruder_stall_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                opcode_i,
  input  logic signed [esd_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic                                extruder_moving_i,
  input  logic                                extruder_pushing_i,
  input  logic                                report_blocked_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                stall_report_o,
  output logic                                stall_suppressed_o,
  output logic                                detected_flag_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [esd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [esd_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  logic                                in_valid_q;
  esd_pkg::esd_cmd_t                   cmd_q;
  logic signed [esd_pkg::SAMPLE_W-1:0] sample_q;
  logic                                out_valid_q;
  esd_pkg::esd_result_t                result_q;
  esd_pkg::esd_result_t                result_d;
  logic                                advance;
  logic                                step;
  logic                                hit;
  logic signed [esd_pkg::THRESH_W-1:0] threshold;

  // Staged word moves on when the result register is free or draining
  assign advance     = !out_valid_q || out_ready_i;
  assign step        = in_valid_q && advance;
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = !step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q.op      <= esd_pkg::esd_op_e'(opcode_i);
      cmd_q.moving  <= extruder_moving_i;
      cmd_q.pushing <= extruder_pushing_i;
      cmd_q.blocked <= report_blocked_i;
      sample_q      <= sample_value_i;
    end
  end

  esd_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step && cmd_q.op == esd_pkg::OP_SAMPLE),
    .sample_i    (sample_q),
    .threshold_i (threshold),
    .hit_o       (hit)
  );

  esd_flags u_flags (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .cmd_i       (cmd_q),
    .hit_i       (hit),
    .threshold_o (threshold),
    .result_o    (result_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign stall_report_o     = result_q.report;
  assign stall_suppressed_o = result_q.suppressed;
  assign detected_flag_o    = result_q.detected;

endmodule

FILE: rtl/esd_filter.sv
module esd_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic signed [esd_pkg::SAMPLE_W-1:0] sample_i,
  input  logic signed [esd_pkg::THRESH_W-1:0] threshold_i,
  output logic                                hit_o
);

  localparam logic signed [esd_pkg::COEF_W-1:0] K1 = esd_pkg::COEF_W'(esd_pkg::K1_VAL);
  localparam logic signed [esd_pkg::COEF_W-1:0] K2 = esd_pkg::COEF_W'(esd_pkg::K2_VAL);

  // taps_q[0] oldest, taps_q[3] newest stored sample
  logic signed [esd_pkg::SAMPLE_W-1:0] taps_q [4];
  logic signed [esd_pkg::DIFF_W-1:0]   diff_outer;
  logic signed [esd_pkg::DIFF_W-1:0]   diff_inner;
  logic signed [esd_pkg::PROD_W-1:0]   prod_outer;
  logic signed [esd_pkg::PROD_W-1:0]   prod_inner;
  logic signed [esd_pkg::Y_W-1:0]      y;

  // Antisymmetric FIR: fold taps, then two constant multiplies
  always_comb begin
    diff_outer = esd_pkg::DIFF_W'(taps_q[0]) - esd_pkg::DIFF_W'(sample_i);
    diff_inner = esd_pkg::DIFF_W'(taps_q[1]) - esd_pkg::DIFF_W'(taps_q[3]);
    prod_outer = esd_pkg::PROD_W'(diff_outer) * esd_pkg::PROD_W'(K1);
    prod_inner = esd_pkg::PROD_W'(diff_inner) * esd_pkg::PROD_W'(K2);
    y          = esd_pkg::Y_W'(prod_outer) + esd_pkg::Y_W'(prod_inner);
    hit_o      = esd_pkg::CMP_W'(y) > esd_pkg::CMP_W'(threshold_i);
  end

  // Delay line shifts on each sample word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) taps_q[i] <= '0;
    end else if (step_i) begin
      taps_q[0] <= taps_q[1];
      taps_q[1] <= taps_q[2];
      taps_q[2] <= taps_q[3];
      taps_q[3] <= sample_i;
    end
  end

endmodule

FILE: rtl/esd_flags.sv
module esd_flags (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic [esd_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [esd_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  step_i,
  input  esd_pkg::esd_cmd_t                     cmd_i,
  input  logic                                  hit_i,
  output logic signed [esd_pkg::THRESH_W-1:0]   threshold_o,
  output esd_pkg::esd_result_t                  result_o
);

  logic signed [esd_pkg::THRESH_W-1:0] threshold_q;
  logic enable_q,   enable_d;
  logic detected_q, detected_d;
  logic reported_q, reported_d;

  assign threshold_o = threshold_q;

  // Flag update and result for the word in flight, config writes otherwise
  always_comb begin
    enable_d   = enable_q;
    detected_d = detected_q;
    reported_d = reported_q;
    result_o   = '0;
    if (step_i) begin
      unique case (cmd_i.op)
        esd_pkg::OP_SAMPLE: begin
          if (hit_i) detected_d = 1'b1;
        end
        esd_pkg::OP_EVAL: begin
          if (!cmd_i.moving || !cmd_i.pushing) begin
            detected_d = 1'b0;
            reported_d = 1'b0;
          end else if (detected_q && !cmd_i.blocked && !reported_q) begin
            reported_d          = 1'b1;
            result_o.report     = enable_q;
            result_o.suppressed = !enable_q;
          end
        end
        default: ;
      endcase
    end else if (cfg_valid_i && cfg_index_i == esd_pkg::REG_ENABLE) begin
      enable_d = cfg_data_i[0];
      // rising enable starts a fresh detection
      if (cfg_data_i[0] && !enable_q) begin
        detected_d = 1'b0;
        reported_d = 1'b0;
      end
    end
    result_o.detected = detected_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      enable_q    <= 1'b0;
      detected_q  <= 1'b0;
      reported_q  <= 1'b0;
    end else begin
      enable_q   <= enable_d;
      detected_q <= detected_d;
      reported_q <= reported_d;
      if (cfg_valid_i && cfg_index_i == esd_pkg::REG_THRESHOLD) begin
        threshold_q <= cfg_data_i;
      end
    end
  end

endmodule

FILE: rtl/esd_checker.sv
`include "assert_macros.svh"

module esd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic stall_report_o,
  input logic stall_suppressed_o,
  input logic detected_flag_o
);

  // A report and a suppression never come together
  `ASSERT_NEVER(a_rep_sup_excl, clk_i, rst_ni, out_valid_o && stall_report_o && stall_suppressed_o, "report and suppressed both set")

  // Any report word carries a set detected flag
  `ASSERT_PROP(a_rep_needs_det, clk_i, rst_ni, out_valid_o && (stall_report_o || stall_suppressed_o) |-> detected_flag_o, "report without detected flag")

  // Input stalls only when a result is held back
  `ASSERT_PROP(a_back_pressure, clk_i, rst_ni, !in_ready_o |-> out_valid_o && !out_ready_i, "input stalled with output free")

  // Stalled result word holds
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(stall_report_o) && $stable(stall_suppressed_o) && $stable(detected_flag_o), "stalled result changed")

endmodule

bind extruder_stall_detector esd_checker u_esd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .stall_report_o     (stall_report_o),
  .stall_suppressed_o (stall_suppressed_o),
  .detected_flag_o    (detected_flag_o)
);
